### design/bfwa_pkg.sv
package bfwa_pkg;

    // Field widths
    localparam int HEIGHT_W = 10;
    localparam int TAG_W    = 16;

    // Mean is at most the largest height, so the quotient fits a height field
    localparam int QUOT_W    = HEIGHT_W;
    // Quotient bits resolved per divider cycle
    localparam int DIV_BITS  = 5;
    localparam int DIV_STEPS = (QUOT_W + DIV_BITS - 1) / DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Input operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Result kinds
    localparam logic KIND_AVERAGE = 1'b0;
    localparam logic KIND_REMOVE  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic take;      // item accepted this cycle
        logic div_step;  // advance the divider
        logic out_load;  // move pending result into the output register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_mode; // mode of the item offered at the input
        logic div_last;  // divider is on its final step
        logic out_free;  // output register can take a result this cycle
    } ctl_status_t;

endpackage

### design/bfwa_ctrl.sv
module bfwa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bfwa_pkg::ctl_status_t status,
    output bfwa_pkg::ctl_cmd_t    cmd
);
    import bfwa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (status.item_mode == MODE_INSERT) ? S_DIV : S_WRITE;
                end
            end
            S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.take     = in_ready && in_valid;
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.out_load = (state_reg == S_WRITE) && status.out_free;

endmodule

### design/bfwa_datapath.sv
module bfwa_datapath #(
    parameter int WINDOW = 5,
    parameter int IDX_W  = 3,
    parameter int CNT_W  = 3,
    parameter int SUM_W  = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bfwa_pkg::ctl_cmd_t              cmd,
    output bfwa_pkg::ctl_status_t           status,
    input  logic                            mode,
    input  logic [bfwa_pkg::HEIGHT_W-1:0]   height_cm,
    input  logic [bfwa_pkg::TAG_W-1:0]      record_tag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            result_kind,
    output logic [bfwa_pkg::HEIGHT_W-1:0]   average_height,
    output logic [bfwa_pkg::TAG_W-1:0]      removed_tag,
    output logic                            empty_error
);
    import bfwa_pkg::*;

    localparam int NUM_W = SUM_W + 1;
    localparam int DEN_W = CNT_W + 1;

    // Record storage, written at the tail, read at the head
    logic [HEIGHT_W-1:0] height_store [WINDOW];
    logic [TAG_W-1:0]    tag_store    [WINDOW];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic [IDX_W-1:0]    head_inc;
    logic [CNT_W:0]      tail_raw;
    logic [IDX_W-1:0]    tail_idx;
    logic                full;
    logic [HEIGHT_W-1:0] head_height;

    // Divider
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  den_shift;
    int                bit_pos;

    // Pending removal report
    logic             pend_kind_reg;
    logic [TAG_W-1:0] pend_tag_reg;
    logic             pend_err_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [HEIGHT_W-1:0] out_avg_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic                out_err_reg;

    assign full        = (count_reg == CNT_W'(WINDOW));
    assign head_height = height_store[head_reg];
    assign head_inc    = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;

    // Tail slot wraps at most once
    always_comb
    begin
        tail_raw = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
        if (tail_raw >= (CNT_W + 1)'(WINDOW))
        begin
            tail_raw = tail_raw - (CNT_W + 1)'(WINDOW);
        end
        tail_idx = full ? head_reg : tail_raw[IDX_W-1:0];
    end

    // FIFO bookkeeping for the accepted item
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (mode == MODE_INSERT)
        begin
            if (full)
            begin
                head_next = head_inc;
                sum_next  = sum_reg - SUM_W'(head_height) + SUM_W'(height_cm);
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(height_cm);
            end
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            sum_next   = sum_reg - SUM_W'(head_height);
            head_next  = (count_reg == CNT_W'(1)) ? '0 : head_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.take)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && (mode == MODE_INSERT))
        begin
            height_store[tail_idx] <= height_cm;
            tag_store[tail_idx]    <= record_tag;
        end
    end

    // Restoring division, DIV_BITS quotient bits per cycle, MSB first
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_shift = '0;
        bit_pos   = 0;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            bit_pos = QUOT_W - 1 - int'(step_reg) * DIV_BITS - j;
            if (bit_pos >= 0)
            begin
                den_shift = NUM_W'(den_reg) << bit_pos;
                if (rem_next >= den_shift)
                begin
                    rem_next  = rem_next - den_shift;
                    quot_next = quot_next | (QUOT_W'(1) << bit_pos);
                end
            end
        end
    end

    // Divider load and steps; numerator 2*sum + n over 2*n gives half-up rounding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.take)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rem_reg  <= {sum_next, 1'b0} + NUM_W'(count_next);
            den_reg  <= {count_next, 1'b0};
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    // Capture the removal report at accept time
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pend_kind_reg <= (mode == MODE_INSERT) ? KIND_AVERAGE : KIND_REMOVE;
            pend_err_reg  <= (mode == MODE_REMOVE) && (count_reg == '0);
            pend_tag_reg  <= ((mode == MODE_REMOVE) && (count_reg != '0))
                             ? tag_store[head_reg] : '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_avg_reg  <= (pend_kind_reg == KIND_AVERAGE) ? quot_reg : '0;
            out_tag_reg  <= pend_tag_reg;
            out_err_reg  <= pend_err_reg;
        end
    end

    assign status.item_mode = mode;
    assign status.div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign average_height = out_avg_reg;
    assign removed_tag    = out_tag_reg;
    assign empty_error    = out_err_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW))
        else $error("entry count beyond window");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < IDX_W'(WINDOW) || WINDOW == (1 << IDX_W))
        else $error("head index out of range");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("empty queue with nonzero sum");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && mode == MODE_INSERT) |=> (count_reg != '0))
        else $error("insert left queue empty");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !cmd.div_step && !cmd.take)
        else $error("result loaded while divider or input busy");

endmodule

### design/bounded_fifo_window_average.sv
// Bounded FIFO window average.
// Input channel (in_valid / in_ready) carries one command per item: mode 0
// inserts a record {height_cm, record_tag}, mode 1 removes the oldest one.
// Up to WINDOW records are held; an insert into a full queue drops the oldest.
// Output channel (out_valid / out_ready) returns exactly one result per item:
// after an insert the half-up rounded mean height of the held records, after a
// remove the popped tag, or empty_error when the queue held nothing.
// Sequence: an insert is accepted, then the mean is produced by a divider that
// resolves five quotient bits per cycle in its divide state, and a write cycle
// moves it to the output register; the next item is accepted after that write.
// A remove needs no division: it goes from accept straight to the write cycle,
// and the next item is accepted after that write.
// The output register lets the block take a new item while the last result
// waits; if the receiver still stalls when the next result is ready, the
// block holds in its write cycle and accepts nothing until the slot frees.
// Reset (rst_n, asynchronous, active low) empties the queue and clears the
// running sum; record storage is not cleared, only held entries are read.
module bounded_fifo_window_average #(
    parameter int WINDOW = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [bfwa_pkg::HEIGHT_W-1:0]   height_cm,
    input  logic [bfwa_pkg::TAG_W-1:0]      record_tag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            result_kind,
    output logic [bfwa_pkg::HEIGHT_W-1:0]   average_height,
    output logic [bfwa_pkg::TAG_W-1:0]      removed_tag,
    output logic                            empty_error
);
    import bfwa_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = HEIGHT_W + CNT_W;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    bfwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bfwa_datapath #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (mode),
        .height_cm      (height_cm),
        .record_tag     (record_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .average_height (average_height),
        .removed_tag    (removed_tag),
        .empty_error    (empty_error)
    );

endmodule

### tb/bounded_fifo_window_average_test.sv
`timescale 1ns / 100ps

module bounded_fifo_window_average_test;

    import bfwa_pkg::*;

    localparam int WINDOW       = 5;
    localparam int RANDOM_ITEMS = 625;
    localparam int PHASE_ITEMS  = 160;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;

    // One result as seen on the output channel
    typedef struct packed {
        logic                kind;
        logic [HEIGHT_W-1:0] mean;
        logic [TAG_W-1:0]    tag;
        logic                empty;
    } result_t;

    // One directed row; want is used only when typed is set
    typedef struct packed {
        logic                cmd;
        logic [HEIGHT_W-1:0] height;
        logic [TAG_W-1:0]    tag;
        logic                typed;
        result_t             want;
    } stim_row_t;

    localparam int DIR_ROWS = 24;

    // Directed sequence: empty-queue removes, extremes, overflow of a full window,
    // drain to empty, refill after empty
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b1, '{KIND_REMOVE,  10'd0,    16'h0000, 1'b1}},
        '{MODE_INSERT, 10'd1023, 16'hFFFF, 1'b1, '{KIND_AVERAGE, 10'd1023, 16'h0000, 1'b0}},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b1, '{KIND_REMOVE,  10'd0,    16'hFFFF, 1'b0}},
        '{MODE_REMOVE, 10'd1023, 16'hFFFF, 1'b1, '{KIND_REMOVE,  10'd0,    16'h0000, 1'b1}},
        '{MODE_INSERT, 10'd0,    16'h0000, 1'b1, '{KIND_AVERAGE, 10'd0,    16'h0000, 1'b0}},
        '{MODE_INSERT, 10'd1,    16'h0001, 1'b0, '0},
        '{MODE_INSERT, 10'd2,    16'h8000, 1'b0, '0},
        '{MODE_INSERT, 10'd1022, 16'h5555, 1'b0, '0},
        '{MODE_INSERT, 10'd1023, 16'hAAAA, 1'b0, '0},
        '{MODE_INSERT, 10'd1023, 16'h1234, 1'b0, '0},
        '{MODE_INSERT, 10'd0,    16'h00FF, 1'b0, '0},
        '{MODE_INSERT, 10'd1023, 16'hFF00, 1'b0, '0},
        '{MODE_INSERT, 10'd1023, 16'h0F0F, 1'b0, '0},
        '{MODE_INSERT, 10'd1023, 16'hF0F0, 1'b0, '0},
        '{MODE_INSERT, 10'd1023, 16'h3C3C, 1'b0, '0},
        '{MODE_INSERT, 10'd1023, 16'hC3C3, 1'b0, '0},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b0, '0},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b0, '0},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b0, '0},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b0, '0},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b0, '0},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b1, '{KIND_REMOVE,  10'd0,    16'h0000, 1'b1}},
        '{MODE_INSERT, 10'd5,    16'hBEEF, 1'b1, '{KIND_AVERAGE, 10'd5,    16'h0000, 1'b0}},
        '{MODE_REMOVE, 10'd0,    16'h0000, 1'b1, '{KIND_REMOVE,  10'd0,    16'hBEEF, 1'b0}}
    };

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                mode       = MODE_INSERT;
    logic [HEIGHT_W-1:0] height_cm  = '0;
    logic [TAG_W-1:0]    record_tag = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                result_kind;
    logic [HEIGHT_W-1:0] average_height;
    logic [TAG_W-1:0]    removed_tag;
    logic                empty_error;

    // Window model: circular record store with running sum
    int      held_height [WINDOW];
    int      held_tag    [WINDOW];
    int      held_head   = 0;
    int      held_count  = 0;
    int      held_sum    = 0;
    result_t pending_results [$];

    int fail_count     = 0;
    int cycle_count    = 0;
    int insert_count   = 0;
    int remove_count   = 0;
    int empty_hits     = 0;
    int full_drops     = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int idle_phase     = 0;

    bounded_fifo_window_average #(
        .WINDOW(WINDOW)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .height_cm      (height_cm),
        .record_tag     (record_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .average_height (average_height),
        .removed_tag    (removed_tag),
        .empty_error    (empty_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the window model by one command and return the result it yields
    function automatic result_t apply_command(logic cmd, logic [HEIGHT_W-1:0] h,
                                              logic [TAG_W-1:0] t);
        result_t r;
        int      slot;
        r = '0;
        if (cmd == MODE_INSERT)
        begin
            insert_count++;
            // full window: oldest record leaves silently
            if (held_count == WINDOW)
            begin
                held_sum  -= held_height[held_head];
                held_head  = (held_head + 1) % WINDOW;
                held_count--;
                full_drops++;
            end
            slot = (held_head + held_count) % WINDOW;
            held_height[slot] = h;
            held_tag[slot]    = t;
            held_count++;
            held_sum += h;
            r.kind = KIND_AVERAGE;
            // half-up rounding of sum / count
            r.mean = HEIGHT_W'((2 * held_sum + held_count) / (2 * held_count));
        end
        else
        begin
            remove_count++;
            r.kind = KIND_REMOVE;
            if (held_count == 0)
            begin
                r.empty = 1'b1;
                empty_hits++;
            end
            else
            begin
                r.tag      = TAG_W'(held_tag[held_head]);
                held_sum  -= held_height[held_head];
                held_head  = (held_head + 1) % WINDOW;
                held_count--;
                if (held_count == 0)
                    held_head = 0;
            end
        end
        return r;
    endfunction

    // Heights lean toward the extremes
    function automatic logic [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return HEIGHT_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Offer one item, hold it until taken, then queue what it should produce.
    // Called at a clock edge; returns at the edge where the item was taken.
    task automatic send_item(input logic cmd, input logic [HEIGHT_W-1:0] h,
                             input logic [TAG_W-1:0] t, input logic typed,
                             input result_t want);
        result_t r;
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_gap_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= cmd;
        height_cm  <= h;
        record_tag <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = apply_command(cmd, h, t);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic set_idle_phase(input int p);
        idle_phase     = p;
        send_gap_pct   = (p == 1) ? 49 : (p == 3) ? 12 : 0;
        recv_stall_pct = (p == 2) ? 49 : (p == 3) ? 12 : 0;
    endtask

    // Hold the input low until every queued result is back
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls and in-order comparison
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing pending: kind %0d mean %0d tag %0h err %0d",
                           result_kind, average_height, removed_tag, empty_error);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                        fail_count++;
                    end
                    if (average_height !== want.mean)
                    begin
                        $error("average_height: expected %0d, got %0d",
                               want.mean, average_height);
                        fail_count++;
                    end
                    if (removed_tag !== want.tag)
                    begin
                        $error("removed_tag: expected %0h, got %0h", want.tag, removed_tag);
                        fail_count++;
                    end
                    if (empty_error !== want.empty)
                    begin
                        $error("empty_error: expected %0d, got %0d", want.empty, empty_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int   sent;
        int   run;
        int   pick;
        int   phase_now;
        logic cmd;

        set_idle_phase(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(directed_rows[i].cmd, directed_rows[i].height, directed_rows[i].tag,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random bursts; the pacing phase changes only with the queue drained
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_now = (sent / PHASE_ITEMS) % 4;
            if (phase_now != idle_phase)
            begin
                wait_until_drained();
                set_idle_phase(phase_now);
            end
            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                // insert run, often long enough to overflow the window
                run = $urandom_range(1, 8);
                for (int k = 0; k < run; k++)
                    send_item(MODE_INSERT, pick_height(), TAG_W'($urandom), 1'b0, '0);
                sent += run;
            end
            else if (pick <= 8)
            begin
                // remove run, sometimes past empty
                run = $urandom_range(1, 6);
                for (int k = 0; k < run; k++)
                    send_item(MODE_REMOVE, pick_height(), TAG_W'($urandom), 1'b0, '0);
                sent += run;
            end
            else
            begin
                // mixed commands
                run = $urandom_range(2, 8);
                for (int k = 0; k < run; k++)
                begin
                    cmd = $urandom_range(0, 1) ? MODE_REMOVE : MODE_INSERT;
                    send_item(cmd, pick_height(), TAG_W'($urandom), 1'b0, '0);
                end
                sent += run;
            end
        end

        // Let everything come back, then a short quiet tail
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d inserts (%0d into a full window) and %0d removes (%0d on empty)",
                 insert_count, full_drops, remove_count, empty_hits);
        $display("under no idling, sender gaps, receiver stalls and both combined.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
design/bfwa_pkg.sv
design/bfwa_ctrl.sv
design/bfwa_datapath.sv
design/bounded_fifo_window_average.sv
tb/bounded_fifo_window_average_test.sv
